[rtl/qspd_pkg.sv]
// types, character codes and helpers shared by the query string pair decoder
package qspd_pkg;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_HI   = 3'b010,
    ESC_LO   = 3'b100
  } esc_phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_EQ    = 2'd1,
    ST_NO_PAIRS = 2'd2
  } status_t;

  typedef struct packed {
    logic       in_value;
    logic       pair_started;
    esc_phase_t esc_phase;
    logic [3:0] high_nibble;
    logic       any_pair_seen;
    logic       failed;
  } dec_state_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       in_value_part;
    logic       pair_done;
    logic       pair_kept;
    logic       query_done;
    status_t    status;
  } result_t;

  localparam dec_state_t STATE_RESET = '{
    in_value:      1'b0,
    pair_started:  1'b0,
    esc_phase:     ESC_NONE,
    high_nibble:   4'd0,
    any_pair_seen: 1'b0,
    failed:        1'b0
  };

  // bit 4 set when the byte is not an upper-case hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (b >= CH_0 && b <= CH_9) begin
        d = b - CH_0;
        hex_digit = {1'b0, d[3:0]};
      end else if (b >= CH_A && b <= CH_F) begin
        d = b - CH_A + 8'd10;
        hex_digit = {1'b0, d[3:0]};
      end else begin
        hex_digit = 5'h10;
      end
    end
  endfunction

endpackage

[rtl/qspd_in_stage.sv]
// input register for one query byte with its stall
module qspd_in_stage import qspd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       take,
  output logic       s_valid,
  output logic [7:0] s_byte,
  output logic       s_last
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  assign in_stall = valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign s_valid = valid_r;
  assign s_byte  = byte_r;
  assign s_last  = last_r;

endmodule

[rtl/qspd_decode.sv]
// next-state and result logic for one query byte
module qspd_decode import qspd_pkg::*; (
  input  dec_state_t  cur,
  input  logic [7:0]  b,
  input  logic        last,
  input  logic        lenient,
  output dec_state_t  nxt,
  output result_t     res,
  output logic        has_result
);

  logic [4:0] digit;

  assign digit = hex_digit(b);

  always_comb begin
    nxt = cur;
    res = '0;
    if (!cur.failed) begin
      if (b == CH_AMP) begin
        if (cur.pair_started) begin
          res.pair_done = 1'b1;
          res.pair_kept = cur.in_value;
          if (!cur.in_value && !lenient) begin
            nxt.failed = 1'b1;
          end
        end
        nxt.in_value     = 1'b0;
        nxt.pair_started = 1'b0;
        nxt.esc_phase    = ESC_NONE;
        nxt.high_nibble  = 4'd0;
      end else begin
        nxt.pair_started  = 1'b1;
        nxt.any_pair_seen = 1'b1;
        if (!cur.in_value) begin
          if (b == CH_EQ) begin
            nxt.in_value  = 1'b1;
            nxt.esc_phase = ESC_NONE;
          end else begin
            res.has_char = 1'b1;
            res.ch       = b;
          end
        end else if (lenient) begin
          res.has_char      = 1'b1;
          res.ch            = b;
          res.in_value_part = 1'b1;
        end else begin
          unique case (cur.esc_phase)
            ESC_HI: begin
              if (!digit[4]) begin
                nxt.high_nibble = digit[3:0];
                nxt.esc_phase   = ESC_LO;
              end else begin
                nxt.esc_phase = ESC_NONE;
              end
            end
            ESC_LO: begin
              if (!digit[4]) begin
                res.has_char      = 1'b1;
                res.ch            = {cur.high_nibble, digit[3:0]};
                res.in_value_part = 1'b1;
              end
              nxt.esc_phase = ESC_NONE;
            end
            default: begin
              if (b == CH_PCT) begin
                nxt.esc_phase = ESC_HI;
              end else begin
                res.has_char      = 1'b1;
                res.ch            = (b == CH_PLUS) ? CH_SPACE : b;
                res.in_value_part = 1'b1;
              end
            end
          endcase
        end
        if (last) begin
          res.pair_done = 1'b1;
          res.pair_kept = nxt.in_value;
          if (!nxt.in_value && !lenient) begin
            nxt.failed = 1'b1;
          end
        end
      end
    end

    if (last) begin
      res.query_done = 1'b1;
      if (nxt.failed) begin
        res.status = ST_NO_EQ;
      end else if (!nxt.any_pair_seen) begin
        res.status = ST_NO_PAIRS;
      end else begin
        res.status = ST_OK;
      end
      nxt = STATE_RESET;
    end
  end

  assign has_result = res.has_char || res.pair_done || res.query_done;

endmodule

[rtl/qspd_out_stage.sv]
// result register facing the output channel
module qspd_out_stage import qspd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[rtl/query_string_pair_decoder.sv]
// Query string pair decoder: splits a query byte stream into name/value bytes
// and pair/query markers, with optional percent and plus decoding of values.
// Input channel: one query byte per beat on in_byte, in_last marks the final
// byte. A beat is taken when in_valid is high and in_stall is low.
// Output channel: at most one result beat per input beat; bytes that only
// open an escape, consume an escape digit, hit '=' in a name or get skipped
// after a failure give no result. out_has_char flags a data byte, and
// out_pair_done / out_query_done mark pair and query ends.
// Path: a byte taken into the input register is decoded into the result
// register once the result register can load; an output stall holds it back.
// Throughput: one byte per cycle, sustained, when the output is not stalled;
// the per-byte state update is a single pass between the two registers.
// cfg_wr_en / cfg_wr_data write lenient mode; write only when idle.
// Reset: both registers empty, pair and escape state cleared, strict mode.
// Stall: out_stall holds the result register; the input register then
// holds its byte and in_stall rises until the result register frees up.
module query_string_pair_decoder import qspd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_has_char,
  output logic [7:0] out_char,
  output logic       out_in_value_part,
  output logic       out_pair_done,
  output logic       out_pair_kept,
  output logic       out_query_done,
  output logic [1:0] out_status
);

  logic       lenient_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_last;
  logic       out_ready;
  logic       take;
  result_t    res;
  logic       has_result;
  result_t    out_res;

  assign take = s_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lenient_r <= 1'b0;
    end else if (cfg_wr_en) begin
      lenient_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (take) begin
      state_r <= state_nxt;
    end
  end

  qspd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .take     (take),
    .s_valid  (s_valid),
    .s_byte   (s_byte),
    .s_last   (s_last)
  );

  qspd_decode u_dec (
    .cur        (state_r),
    .b          (s_byte),
    .last       (s_last),
    .lenient    (lenient_r),
    .nxt        (state_nxt),
    .res        (res),
    .has_result (has_result)
  );

  qspd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && has_result),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_has_char      = out_res.has_char;
  assign out_char          = out_res.ch;
  assign out_in_value_part = out_res.in_value_part;
  assign out_pair_done     = out_res.pair_done;
  assign out_pair_kept     = out_res.pair_kept;
  assign out_query_done    = out_res.query_done;
  assign out_status        = out_res.status;

endmodule

[rtl/qspd_checker.sv]
// port-level checks for the query string pair decoder, bound to the top level
module qspd_checker import qspd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_has_char,
  input logic [7:0] out_char,
  input logic       out_in_value_part,
  input logic       out_pair_done,
  input logic       out_pair_kept,
  input logic       out_query_done,
  input logic [1:0] out_status
);

  // a stalled beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // no beat without something to report
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_has_char || out_pair_done || out_query_done)
    else $error("empty result beat");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_char |-> out_char == 8'd0 && !out_in_value_part)
    else $error("stray char fields without a char");

  a_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pair_kept |-> out_pair_done)
    else $error("pair kept without pair end");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_query_done && (out_status == ST_NO_EQ || out_status == ST_NO_PAIRS))
    else $error("bad status outside query end");

endmodule

bind query_string_pair_decoder qspd_checker u_qspd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_has_char      (out_has_char),
  .out_char          (out_char),
  .out_in_value_part (out_in_value_part),
  .out_pair_done     (out_pair_done),
  .out_pair_kept     (out_pair_kept),
  .out_query_done    (out_query_done),
  .out_status        (out_status)
);

[tb/sv/query_string_pair_decoder_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the query string pair decoder with a byte-level decode predictor
module query_string_pair_decoder_tb;
  import qspd_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } qbyte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_has_char;
  logic [7:0] out_char;
  logic       out_in_value_part;
  logic       out_pair_done;
  logic       out_pair_kept;
  logic       out_query_done;
  logic [1:0] out_status;

  qbyte_t     query_bytes[$];
  result_t    decoded_q[$];
  dec_state_t dec = STATE_RESET;
  logic       lenient = 1'b0;
  logic       in_taken = 1'b0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int bytes_queued = 0;
  int bytes_sent = 0;
  int beats_seen = 0;
  int chars_seen = 0;
  int pairs_kept = 0;
  int pairs_dropped = 0;
  int status_seen[3] = '{default: 0};

  query_string_pair_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_has_char      (out_has_char),
    .out_char          (out_char),
    .out_in_value_part (out_in_value_part),
    .out_pair_done     (out_pair_done),
    .out_pair_kept     (out_pair_kept),
    .out_query_done    (out_query_done),
    .out_status        (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // upper-case hex value of a byte, -1 when it is not a digit
  function automatic int nibble_of(input logic [7:0] b);
    if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
    if (b >= CH_A && b <= CH_F) return int'(b - CH_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input int n);
    return (n < 10) ? CH_0 + 8'(n) : CH_A + 8'(n - 10);
  endfunction

  task automatic note_fault(input string msg);
    errors++;
    $display("%0t ns  %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      note_fault($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic end_pair(inout result_t r);
    r.pair_done = 1'b1;
    r.pair_kept = dec.in_value;
    if (!dec.in_value && !lenient) dec.failed = 1'b1;
  endtask

  task automatic clear_pair();
    dec.in_value = 1'b0;
    dec.pair_started = 1'b0;
    dec.esc_phase = ESC_NONE;
    dec.high_nibble = 4'd0;
  endtask

  // advance the decoder state by one byte and queue the result beat it should give
  task automatic decode_byte(input logic [7:0] b, input logic is_last);
    result_t r;
    int d;
    r = '0;
    d = nibble_of(b);
    if (!dec.failed) begin
      if (b == CH_AMP) begin
        if (dec.pair_started) end_pair(r);
        clear_pair();
      end else begin
        dec.pair_started = 1'b1;
        dec.any_pair_seen = 1'b1;
        if (!dec.in_value) begin
          if (b == CH_EQ) begin
            dec.in_value = 1'b1;
            dec.esc_phase = ESC_NONE;
          end else begin
            r.has_char = 1'b1;
            r.ch = b;
          end
        end else if (lenient) begin
          r.has_char = 1'b1;
          r.ch = b;
          r.in_value_part = 1'b1;
        end else if (dec.esc_phase == ESC_HI) begin
          if (d >= 0) begin
            dec.high_nibble = 4'(d);
            dec.esc_phase = ESC_LO;
          end else begin
            dec.esc_phase = ESC_NONE;
          end
        end else if (dec.esc_phase == ESC_LO) begin
          if (d >= 0) begin
            r.has_char = 1'b1;
            r.ch = {dec.high_nibble, 4'(d)};
            r.in_value_part = 1'b1;
          end
          dec.esc_phase = ESC_NONE;
        end else if (b == CH_PCT) begin
          dec.esc_phase = ESC_HI;
        end else begin
          r.has_char = 1'b1;
          r.ch = (b == CH_PLUS) ? CH_SPACE : b;
          r.in_value_part = 1'b1;
        end
        if (is_last) end_pair(r);
      end
    end
    if (is_last) begin
      r.query_done = 1'b1;
      if (dec.failed) r.status = ST_NO_EQ;
      else if (!dec.any_pair_seen) r.status = ST_NO_PAIRS;
      else r.status = ST_OK;
      clear_pair();
      dec.any_pair_seen = 1'b0;
      dec.failed = 1'b0;
    end
    if (r.has_char || r.pair_done || r.query_done) decoded_q.push_back(r);
  endtask

  task automatic check_result();
    result_t want;
    beats_seen++;
    if (decoded_q.size() == 0) begin
      note_fault($sformatf("result beat with nothing pending, char %02h", out_char));
    end else begin
      want = decoded_q.pop_front();
      compare_field("has_char", 8'(out_has_char), 8'(want.has_char));
      compare_field("char", out_char, want.ch);
      compare_field("in_value_part", 8'(out_in_value_part), 8'(want.in_value_part));
      compare_field("pair_done", 8'(out_pair_done), 8'(want.pair_done));
      compare_field("pair_kept", 8'(out_pair_kept), 8'(want.pair_kept));
      compare_field("query_done", 8'(out_query_done), 8'(want.query_done));
      compare_field("status", 8'(out_status), 8'(want.status));
      if (want.has_char) chars_seen++;
      if (want.pair_done) begin
        if (want.pair_kept) pairs_kept++;
        else pairs_dropped++;
      end
      if (want.query_done) status_seen[int'(want.status)]++;
    end
  endtask

  // monitor: register writes, accepted input beats and accepted result beats
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (cfg_wr_en) lenient = cfg_wr_data;
      if (in_taken) decode_byte(in_byte, in_last);
    end
  end

  always @(negedge clk) begin : drive
    qbyte_t nx;
    if (rst_n && (!in_valid || in_taken)) begin
      if (query_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        nx = query_bytes.pop_front();
        in_valid <= 1'b1;
        in_byte <= nx.b;
        in_last <= nx.last;
        bytes_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receive
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 240;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic is_last);
    query_bytes.push_back('{b: b, last: is_last});
    bytes_queued++;
  endtask

  task automatic add_text(input string s, input logic ends_query);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], ends_query && i == s.len() - 1);
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] b;
    do begin
      if ($urandom_range(3, 0) == 0) b = 8'($urandom_range(255, 0));
      else b = 8'($urandom_range(8'h7E, 8'h21));
    end while (b == CH_AMP || b == CH_EQ);
    return b;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0)); while (nibble_of(b) >= 0 || b == CH_AMP);
    return b;
  endfunction

  task automatic add_value_token(ref logic [7:0] qb[$]);
    case ($urandom_range(12, 0))
      4: qb.push_back(CH_PLUS);
      5, 6: begin
        qb.push_back(CH_PCT);
        qb.push_back(hex_char($urandom_range(15, 0)));
        qb.push_back(hex_char($urandom_range(15, 0)));
      end
      7: begin
        qb.push_back(CH_PCT);
        qb.push_back(non_hex());
      end
      8: begin
        qb.push_back(CH_PCT);
        qb.push_back(hex_char($urandom_range(15, 0)));
        qb.push_back(non_hex());
      end
      // lone escape openers, completed by the next token or cut off at the pair end
      9: qb.push_back(CH_PCT);
      10: begin
        qb.push_back(CH_PCT);
        qb.push_back(hex_char($urandom_range(15, 0)));
      end
      11: qb.push_back(CH_EQ);
      12: qb.push_back(8'($urandom_range(255, 0)));
      default: qb.push_back(name_char());
    endcase
  endtask

  // mostly well-formed queries with random content, some raw noise
  task automatic add_query();
    logic [7:0] qb[$];
    int npairs;
    if ($urandom_range(7, 0) == 0) begin
      repeat ($urandom_range(12, 1)) qb.push_back(8'($urandom_range(255, 0)));
    end else begin
      npairs = $urandom_range(4, 0);
      for (int p = 0; p < npairs; p++) begin
        if (p != 0 || $urandom_range(5, 0) == 0) qb.push_back(CH_AMP);
        if ($urandom_range(5, 0) == 0) qb.push_back(CH_AMP);
        repeat ($urandom_range(4, 0)) qb.push_back(name_char());
        if ($urandom_range(15, 0) != 0) begin
          qb.push_back(CH_EQ);
          repeat ($urandom_range(5, 0)) add_value_token(qb);
        end
      end
      if (qb.size() == 0 || $urandom_range(3, 0) == 0) qb.push_back(CH_AMP);
    end
    foreach (qb[i]) add_byte(qb[i], i == qb.size() - 1);
  endtask

  // wait until every queued byte is sent, every pending beat has come back and the pipe is empty
  task automatic wait_idle();
    int waited;
    waited = 0;
    while ((query_bytes.size() != 0 || in_valid || decoded_q.size() != 0) && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (decoded_q.size() != 0) begin
      note_fault($sformatf("%0d result beats never arrived", decoded_q.size()));
      decoded_q.delete();
    end
  endtask

  task automatic set_mode(input logic m);
    wait_idle();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin : stimulus
    int phase_idle[5];
    int phase_stall[5];
    int start;
    phase_idle = '{0, 80, 0, 36, 0};
    phase_stall = '{0, 0, 80, 36, 0};
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_mode(1'b0);
    // query with no pairs at all
    add_byte(CH_AMP, 1'b1);
    // later equals, good escape, plus, bad first and second digits, escape cut off at the end
    add_text("a==%4F+%g%1x%3", 1'b1);
    // extreme name bytes, then a pair without equals fails the query
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(CH_AMP, 1'b0);
    add_text("b", 1'b1);
    // mode switched half way through a query with an escape pending
    add_text("v=%", 1'b0);
    set_mode(1'b1);
    add_text("%+&m", 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      set_mode(1'(ph % 2));
      send_idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      start = bytes_queued;
      while (bytes_queued - start < 340) add_query();
      if (ph == 0) begin
        // long receiver hold-off with the sender still offering beats
        repeat (20) @(posedge clk);
        hold_req++;
      end
      wait_idle();
    end

    $display("sent %0d bytes in %0d queries (ok %0d, missing equals %0d, no pairs %0d)",
             bytes_sent, status_seen[0] + status_seen[1] + status_seen[2],
             status_seen[0], status_seen[1], status_seen[2]);
    $display("%0d result beats, %0d data bytes, %0d pairs kept, %0d dropped, both modes",
             beats_seen, chars_seen, pairs_kept, pairs_dropped);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("timed out waiting for the decoder");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
